// ----- design/csb_pkg.sv -----
package csb_pkg;

	localparam int CSB_WIDTH    = 32;
	localparam int CSB_MAX_ITER = 32;

	localparam int ANGLE_W     = 32;
	localparam int SINE_W      = 32;
	localparam int ITER_W      = 6;
	localparam int GAIN_W      = 31;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 31;

	localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_COUNT = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_START      = CFG_INDEX_W'(1);

	localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(32);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1304065748);

	localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_152A;

	// Restoring long division, used only while the arctangent table is elaborated.
	function automatic logic [63:0] csb_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-idx)/(pi/2) in Q0.64, from the arctangent series.
	function automatic logic [63:0] csb_atan_q64(input int idx);
		logic [63:0]  sum;
		logic [63:0]  term;
		logic [63:0]  odd;
		logic [127:0] prod;
		int           e;
		if (idx == 0) begin
			return 64'h8000_0000_0000_0000;
		end
		sum = '0;
		for (int k = 0; k < 32; k++) begin
			e = idx * (2 * k + 1);
			if (e < 64) begin
				odd  = 64'(2 * k + 1);
				term = csb_udiv(64'd1 << (64 - e), odd);
				if (k[0] == 1'b0) begin
					sum = sum + term;
				end else begin
					sum = sum - term;
				end
			end
		end
		prod = {64'd0, sum} * {64'd0, TWO_OVER_PI_Q64};
		return prod[127:64];
	endfunction

	// Table entry rounded half up to width-1 fraction bits.
	function automatic logic [63:0] csb_atan_entry(input int idx, input int width);
		logic [63:0] v;
		v = csb_atan_q64(idx);
		return ((v >> (64 - width)) + 64'd1) >> 1;
	endfunction

endpackage

// ----- design/csb_rotate.sv -----
module csb_rotate import csb_pkg::*; #(
	parameter int WIDTH = CSB_WIDTH,
	parameter int SHIFT_W = 5
) (
	input  logic [WIDTH-1:0]   x,
	input  logic [WIDTH-1:0]   y,
	input  logic [WIDTH-1:0]   z,
	input  logic [SHIFT_W-1:0] shift,
	input  logic [WIDTH-1:0]   atan,
	output logic [WIDTH-1:0]   x_next,
	output logic [WIDTH-1:0]   y_next,
	output logic [WIDTH-1:0]   z_next
);

	logic [WIDTH-1:0] xs;
	logic [WIDTH-1:0] ys;

	assign xs = WIDTH'($signed(x) >>> shift);
	assign ys = WIDTH'($signed(y) >>> shift);

	// The sign of the residual angle decides the direction of the micro-rotation.
	always_comb begin
		if (z[WIDTH-1] == 1'b0) begin
			x_next = x - ys;
			y_next = y + xs;
			z_next = z - atan;
		end else begin
			x_next = x + ys;
			y_next = y - xs;
			z_next = z + atan;
		end
	end

endmodule

// ----- design/cordic_sine_bam.sv -----
// Channel   Direction  Handshake                  Payload
// angle     in         angle_valid / angle_ready  angle [31:0], binary angle
// sine      out        sine_valid / sine_ready    sine [31:0], signed Q1.31
// config    in         cfg_wr_en (no wait)        cfg_index, cfg_data
//
// An accepted angle keeps the block busy until its result is stored; only then can a new
// angle be accepted. With n the iteration_count limited to MAX_ITER, n micro-rotations run
// one per cycle through the single shift-add unit, then a final step selects and stores the
// result. The sine is shown in the same cycle that angle_ready rises again.
// Reset returns the sequencer to idle and the registers to their default values.
// A stalled sine only holds the block at the end of the following transaction.
module cordic_sine_bam import csb_pkg::*; #(
	parameter int WIDTH    = CSB_WIDTH,
	parameter int MAX_ITER = CSB_MAX_ITER
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   angle_valid,
	output logic                   angle_ready,
	input  logic [ANGLE_W-1:0]     angle,
	output logic                   sine_valid,
	input  logic                   sine_ready,
	output logic [SINE_W-1:0]      sine,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_ITER + 1);
	localparam int IDX_W = $clog2(MAX_ITER);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [ITER_W-1:0] iter_cnt_q;
	logic [GAIN_W-1:0] gain_q;
	logic [CNT_W-1:0]  iter_q;
	logic [CNT_W-1:0]  n_eff;
	logic [WIDTH-1:0]  x_q, y_q, z_q;
	logic [1:0]        quad_q;
	logic [WIDTH-1:0]  res_q;
	logic              out_valid_q;

	logic [WIDTH-1:0]        atan_rom [MAX_ITER];
	logic [WIDTH-1:0]        x_nx, y_nx, z_nx;
	logic [WIDTH+GAIN_W-1:0] gain_wide;
	logic [WIDTH+ANGLE_W-1:0] angle_wide;
	logic [WIDTH-1:0]        ang;
	logic [WIDTH-1:0]        sel;
	logic [WIDTH-1:0]        sel_out;
	logic [WIDTH+SINE_W-1:0] res_wide;
	logic                    in_fire;
	logic                    out_fire;
	logic                    last;
	logic                    finish;

	for (genvar g = 0; g < MAX_ITER; g++) begin : g_rom
		localparam logic [63:0] ENTRY = csb_atan_entry(g, WIDTH);
		assign atan_rom[g] = ENTRY[WIDTH-1:0];
	end

	assign n_eff = (iter_cnt_q > ITER_W'(MAX_ITER)) ? CNT_W'(MAX_ITER) : CNT_W'(iter_cnt_q);

	assign gain_wide  = {{WIDTH{1'b0}}, gain_q};
	assign angle_wide = {{WIDTH{1'b0}}, angle};
	assign ang        = angle_wide[WIDTH-1:0];

	assign angle_ready = (state_q == ST_IDLE);
	assign in_fire     = angle_valid && angle_ready;
	assign out_fire    = out_valid_q && sine_ready;
	assign last        = (state_q == ST_RUN) && (iter_q == n_eff);
	assign finish      = last && (!out_valid_q || sine_ready);

	csb_rotate #(
		.WIDTH   (WIDTH),
		.SHIFT_W (IDX_W)
	) u_rotate (
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.shift  (iter_q[IDX_W-1:0]),
		.atan   (atan_rom[iter_q[IDX_W-1:0]]),
		.x_next (x_nx),
		.y_next (y_nx),
		.z_next (z_nx)
	);

	assign sel     = quad_q[0] ? x_q : y_q;
	assign sel_out = quad_q[1] ? (WIDTH'(0) - sel) : sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cnt_q <= ITER_RESET;
			gain_q     <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ITERATION_COUNT: iter_cnt_q <= cfg_data[ITER_W-1:0];
				REG_GAIN_START:      gain_q     <= cfg_data[GAIN_W-1:0];
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						iter_q  <= '0;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (!last) begin
						iter_q <= iter_q + CNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= gain_wide[WIDTH-1:0];
			y_q    <= '0;
			z_q    <= {ang[WIDTH-3:0], 1'b0};
			quad_q <= ang[WIDTH-1:WIDTH-2];
		end else if ((state_q == ST_RUN) && !last) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (finish) begin
			res_q <= sel_out;
		end
	end

	assign res_wide   = {{SINE_W{res_q[WIDTH-1]}}, res_q};
	assign sine       = res_wide[SINE_W-1:0];
	assign sine_valid = out_valid_q;

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (iter_q <= n_eff))
		else $error("iteration counter ran past the iteration limit");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_RUN) && (iter_q == '0))
		else $error("accepted transaction did not start at the first micro-rotation");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> sine_valid && (state_q == ST_IDLE))
		else $error("finished transaction did not present a result");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sine_valid) |-> $past(state_q == ST_RUN))
		else $error("result appeared without a transaction in progress");

endmodule

// ----- tb/sv/cordic_sine_bam_checker.sv -----
module cordic_sine_bam_checker import csb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   angle_valid,
	input  logic                   angle_ready,
	input  logic [ANGLE_W-1:0]     angle,
	input  logic                   sine_valid,
	input  logic                   sine_ready,
	input  logic [SINE_W-1:0]      sine,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pending,
	output int                     compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [SINE_W-1:0]  sine;
	} sine_expectation_t;

	logic [SINE_W-1:0]  atan_quarter_turns [CSB_MAX_ITER];
	logic [ITER_W-1:0]  iter_reg;
	logic [GAIN_W-1:0]  gain_reg;
	sine_expectation_t  expected_sines [$];
	sine_expectation_t  oldest;
	sine_expectation_t  incoming;

	// atan(2^-i) as a fraction of a quarter turn, scaled so that 1.0 is 2^31.
	function automatic logic [SINE_W-1:0] atan_entry(input int i);
		logic [63:0]  series;
		logic [63:0]  term;
		logic [63:0]  v;
		logic [127:0] prod;
		int           k;
		int           e;
		if (i == 0) begin
			v = 64'h8000_0000_0000_0000;
		end else begin
			series = '0;
			k = 0;
			e = i;
			while (e < 64) begin
				term = (64'd1 << (64 - e)) / 64'(2 * k + 1);
				if (k % 2 == 0) begin
					series = series + term;
				end else begin
					series = series - term;
				end
				k = k + 1;
				e = i * (2 * k + 1);
			end
			prod = {64'd0, series} * {64'd0, TWO_OVER_PI_Q64};
			v = prod[127:64];
		end
		return SINE_W'(((v >> (64 - CSB_WIDTH)) + 64'd1) >> 1);
	endfunction

	function automatic logic [SINE_W-1:0] cordic_sine(input logic [ANGLE_W-1:0] a);
		logic signed [CSB_WIDTH-1:0] x;
		logic signed [CSB_WIDTH-1:0] y;
		logic signed [CSB_WIDTH-1:0] z;
		logic signed [CSB_WIDTH-1:0] xs;
		logic signed [CSB_WIDTH-1:0] ys;
		logic signed [CSB_WIDTH-1:0] r;
		int                          n;
		int                          i;
		n = (int'(iter_reg) > CSB_MAX_ITER) ? CSB_MAX_ITER : int'(iter_reg);
		x = {1'b0, gain_reg};
		y = '0;
		z = {a[CSB_WIDTH-3:0], 1'b0};
		for (i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (!z[CSB_WIDTH-1]) begin
				x = x - ys;
				y = y + xs;
				z = z - atan_quarter_turns[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + atan_quarter_turns[i];
			end
		end
		r = a[CSB_WIDTH-2] ? x : y;
		if (a[CSB_WIDTH-1]) begin
			r = -r;
		end
		return r;
	endfunction

	initial begin : build_table
		int j;
		for (j = 0; j < CSB_MAX_ITER; j++) begin
			atan_quarter_turns[j] = atan_entry(j);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_reg = ITER_RESET;
			gain_reg = GAIN_RESET;
			expected_sines.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ITERATION_COUNT: iter_reg = cfg_data[ITER_W-1:0];
					REG_GAIN_START: gain_reg = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			// The output side is settled first so that a queue never goes negative.
			if (sine_valid && sine_ready) begin
				if (expected_sines.size() == 0) begin
					$display("%0t: unexpected sine transaction %h", $time, sine);
					errors <= errors + 1;
				end else begin
					oldest = expected_sines.pop_front();
					compared <= compared + 1;
					if (sine !== oldest.sine) begin
						$display("%0t: sine of angle %h expected %h, got %h",
							$time, oldest.angle, oldest.sine, sine);
						errors <= errors + 1;
					end
				end
			end
			if (angle_valid && angle_ready) begin
				incoming.angle = angle;
				incoming.sine  = cordic_sine(angle);
				expected_sines = {expected_sines, incoming};
			end
			pending <= expected_sines.size();
		end
	end

endmodule

// ----- tb/sv/cordic_sine_bam_tb.sv -----
module cordic_sine_bam_tb import csb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

	localparam int NUM_SETTINGS    = 9;
	localparam int ANGLES_PER_SET  = 200;
	localparam int LONG_HOLD       = 300;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = CSB_MAX_ITER + 8;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   angle_valid = 1'b0;
	logic                   angle_ready;
	logic [ANGLE_W-1:0]     angle       = '0;
	logic                   sine_valid;
	logic                   sine_ready  = 1'b0;
	logic [SINE_W-1:0]      sine;
	logic                   cfg_wr_en   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = REG_ITERATION_COUNT;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	int errors;
	int pending;
	int compared;
	int angles_sent = 0;
	int quiet_cycles = 0;
	int holds_asked = 0;
	int holds_done = 0;
	bit sender_fast = 1'b0;
	bit receiver_fast = 1'b0;

	logic [ANGLE_W-1:0] corner_angles [20] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
		32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'hBFFF_FFFF, 32'h0000_0001, 32'h4000_0001,
		32'h8000_0001, 32'hC000_0001, 32'h2000_0000, 32'h6000_0000, 32'hA000_0000,
		32'hE000_0000, 32'h1555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA
	};

	always #5 clk = ~clk;

	cordic_sine_bam i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_ready (angle_ready),
		.angle       (angle),
		.sine_valid  (sine_valid),
		.sine_ready  (sine_ready),
		.sine        (sine),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	cordic_sine_bam_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_ready (angle_ready),
		.angle       (angle),
		.sine_valid  (sine_valid),
		.sine_ready  (sine_ready),
		.sine        (sine),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.compared    (compared)
	);

	// Half uniform angles, the other half clustered on quadrant edges and at 45 degrees within a quadrant.
	function automatic logic [ANGLE_W-1:0] random_angle();
		logic [1:0] quad;
		quad = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			4: return {quad, ($urandom_range(0, 1) == 1) ? 30'h3FFF_FFFF : 30'h0};
			5: return {quad, 30'($urandom_range(0, 255))};
			6: return {quad, 30'h3FFF_FFFF - 30'($urandom_range(0, 255))};
			7: return {quad, 30'h2000_0000 + 30'($urandom_range(0, 511)) - 30'd256};
			default: return $urandom;
		endcase
	endfunction

	function automatic int sender_gap();
		return sender_fast ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic send_angle(input logic [ANGLE_W-1:0] a, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			angle_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		angle_valid <= 1'b1;
		angle       <= a;
		do @(posedge clk); while (!angle_ready);
		angles_sent++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Registers may only change once the block has nothing in flight.
	task automatic drain();
		@(negedge clk);
		angle_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input int s);
		sender_fast   = 1'b0;
		receiver_fast = 1'b0;
		case (s)
			0: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(ITER_RESET));
				write_reg(REG_GAIN_START, CFG_DATA_W'(GAIN_RESET));
			end
			1: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(4));
				write_reg(REG_GAIN_START, 31'h7FFF_FFFF);
			end
			2: begin
				// Writes to the unused indexes must leave both registers alone.
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(63));
				write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
			end
			3: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(0));
				write_reg(REG_GAIN_START, CFG_DATA_W'($urandom));
			end
			4: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(3));
				write_reg(REG_GAIN_START, '0);
			end
			5: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(33));
				write_reg(REG_GAIN_START, CFG_DATA_W'($urandom));
				sender_fast   = 1'b1;
				receiver_fast = 1'b1;
				holds_asked++;
			end
			6: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'($urandom_range(0, 63)));
				write_reg(REG_GAIN_START, CFG_DATA_W'($urandom));
				sender_fast = 1'b1;
			end
			7: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(1));
				write_reg(REG_GAIN_START, CFG_DATA_W'($urandom));
			end
			default: begin
				write_reg(REG_ITERATION_COUNT, CFG_DATA_W'(ITER_RESET));
				write_reg(REG_GAIN_START, CFG_DATA_W'(GAIN_RESET));
				receiver_fast = 1'b1;
			end
		endcase
	endtask

	initial begin : receiver
		int stall;
		forever begin
			if (holds_asked > holds_done) begin
				stall = LONG_HOLD;
				holds_done++;
			end else if (receiver_fast) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 10);
			end
			if (stall > 0) begin
				@(negedge clk);
				sine_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			sine_ready <= 1'b1;
			do @(posedge clk); while (!sine_valid);
		end
	end

	always @(posedge clk) begin
		if ((angle_valid && angle_ready) || (sine_valid && sine_ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int s;
		int k;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (corner_angles[i]) begin
			send_angle(corner_angles[i], ($urandom_range(0, 1) == 1) ? 0 : sender_gap());
		end
		drain();

		for (s = 0; s < NUM_SETTINGS; s++) begin
			apply_setting(s);
			for (k = 0; k < ANGLES_PER_SET; k++) begin
				send_angle(random_angle(), sender_gap());
			end
			drain();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d angles sent and %0d sines compared over %0d register settings.",
			angles_sent, compared, NUM_SETTINGS + 1);
		$display("Iteration counts from 0 to 63, gains from 0 to full scale, with gaps, "
			, "back-pressure and one long output stall.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- cordic_sine_bam.f -----
design/csb_pkg.sv
design/csb_rotate.sv
design/cordic_sine_bam.sv
tb/sv/cordic_sine_bam_checker.sv
tb/sv/cordic_sine_bam_tb.sv
